@@ rtl/mpeg_audio_frame_header_eval_top_defines.svh @@
// ---------------------------------------------------------------------------
// MPEG audio frame header evaluator - assertion macros
// Shared concurrent assertion forms for the evaluator RTL.
// ---------------------------------------------------------------------------
`ifndef MPEG_AUDIO_FRAME_HEADER_EVAL_TOP_DEFINES_SVH
`define MPEG_AUDIO_FRAME_HEADER_EVAL_TOP_DEFINES_SVH

// same-cycle implication, disabled during reset
`define MAFH_ASSERT_IMP(name, clk, rst, ante, cons, msg) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication, disabled during reset
`define MAFH_ASSERT_NXT(name, clk, rst, ante, cons, msg) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

@@ rtl/mafh_pkg.sv @@
// ---------------------------------------------------------------------------
// MPEG audio frame header evaluator - package
// Header tables, status codes, divider constants and the stage word type.
// ---------------------------------------------------------------------------
`default_nettype none

package mafh_pkg;

   localparam int PIPE_DEPTH  = 5;
   localparam int RECIP_SHIFT = 20;
   localparam int X_W         = 20;
   localparam int RECIP_W     = 17;
   localparam int DEN_W       = 9;
   localparam int SCALE_W     = 12;
   localparam int Q_W         = 11;

   localparam logic [2:0] STAT_OK        = 3'd0;
   localparam logic [2:0] STAT_FREE      = 3'd1;
   localparam logic [2:0] STAT_BAD_RATE  = 3'd2;
   localparam logic [2:0] STAT_RSV_LAYER = 3'd3;
   localparam logic [2:0] STAT_RSV_FREQ  = 3'd4;

   localparam logic [1:0] LAYER_RSV   = 2'd0;
   localparam logic [1:0] LAYER_ONE   = 2'd3;
   localparam logic [1:0] FREQ_RSV    = 2'd3;
   localparam logic [3:0] RIDX_FREE   = 4'd0;
   localparam logic [3:0] RIDX_BAD    = 4'd15;
   localparam logic [7:0] LAYER_ONE_K = 8'd12;

   localparam logic [8:0] KBPS_TAB [2][4][16] = '{
      '{
         '{9'd0, 9'd0, 9'd0, 9'd0, 9'd0, 9'd0, 9'd0, 9'd0,
           9'd0, 9'd0, 9'd0, 9'd0, 9'd0, 9'd0, 9'd0, 9'd0},
         '{9'd0, 9'd8, 9'd16, 9'd24, 9'd32, 9'd40, 9'd48, 9'd56,
           9'd64, 9'd80, 9'd96, 9'd112, 9'd128, 9'd144, 9'd160, 9'd0},
         '{9'd0, 9'd8, 9'd16, 9'd24, 9'd32, 9'd40, 9'd48, 9'd56,
           9'd64, 9'd80, 9'd96, 9'd112, 9'd128, 9'd144, 9'd160, 9'd0},
         '{9'd0, 9'd32, 9'd48, 9'd56, 9'd64, 9'd80, 9'd96, 9'd112,
           9'd128, 9'd144, 9'd160, 9'd176, 9'd192, 9'd224, 9'd256, 9'd0}
      },
      '{
         '{9'd0, 9'd0, 9'd0, 9'd0, 9'd0, 9'd0, 9'd0, 9'd0,
           9'd0, 9'd0, 9'd0, 9'd0, 9'd0, 9'd0, 9'd0, 9'd0},
         '{9'd0, 9'd32, 9'd40, 9'd48, 9'd56, 9'd64, 9'd80, 9'd96,
           9'd112, 9'd128, 9'd160, 9'd192, 9'd224, 9'd256, 9'd320, 9'd0},
         '{9'd0, 9'd32, 9'd48, 9'd56, 9'd64, 9'd80, 9'd96, 9'd112,
           9'd128, 9'd160, 9'd192, 9'd224, 9'd256, 9'd320, 9'd384, 9'd0},
         '{9'd0, 9'd32, 9'd64, 9'd96, 9'd128, 9'd160, 9'd192, 9'd224,
           9'd256, 9'd288, 9'd320, 9'd352, 9'd384, 9'd416, 9'd448, 9'd0}
      }
   };

   localparam logic [15:0] HZ_TAB [2][4] = '{
      '{16'd22050, 16'd24000, 16'd16000, 16'd0},
      '{16'd44100, 16'd48000, 16'd32000, 16'd0}
   };

   localparam logic [10:0] SPF_TAB [2][4] = '{
      '{11'd0, 11'd576, 11'd1152, 11'd384},
      '{11'd0, 11'd1152, 11'd1152, 11'd384}
   };

   localparam logic [1:0] CHAN_TAB [4] = '{2'd2, 2'd2, 2'd2, 2'd1};
   localparam logic [2:0] SLOT_TAB [4] = '{3'd0, 3'd1, 3'd1, 3'd4};

   // 1000 / rate = num / den, den reciprocal = floor(2^20 / den)
   localparam logic [4:0] NUM_TAB [2][4] = '{
      '{5'd20, 5'd1, 5'd1, 5'd0},
      '{5'd10, 5'd1, 5'd1, 5'd0}
   };

   localparam logic [DEN_W-1:0] DEN_TAB [2][4] = '{
      '{9'd441, 9'd24, 9'd16, 9'd16},
      '{9'd441, 9'd48, 9'd32, 9'd16}
   };

   localparam logic [RECIP_W-1:0] RECIP_TAB [2][4] = '{
      '{17'd2377, 17'd43690, 17'd65536, 17'd65536},
      '{17'd2377, 17'd21845, 17'd32768, 17'd65536}
   };

   typedef struct packed {
      logic [8:0]  kbps;
      logic [15:0] hz;
      logic [1:0]  chans;
      logic [10:0] spf;
      logic [2:0]  status;
      logic [2:0]  slot;
      logic        layer_one;
   } hdr_info_type;

   function automatic logic [2:0] status_eval(input logic [1:0] lay, input logic [1:0] fri,
                                              input logic [3:0] bri);
      logic [2:0] st;
      if (lay == LAYER_RSV) begin
         st = STAT_RSV_LAYER;
      end else if (fri == FREQ_RSV) begin
         st = STAT_RSV_FREQ;
      end else if (bri == RIDX_FREE) begin
         st = STAT_FREE;
      end else if (bri == RIDX_BAD) begin
         st = STAT_BAD_RATE;
      end else begin
         st = STAT_OK;
      end
      return st;
   endfunction

   function automatic logic [SCALE_W-1:0] scale_eval(input logic ver, input logic [1:0] lay,
                                                     input logic [1:0] fri);
      logic [7:0]  k;
      logic [12:0] prod;
      k    = (lay == LAYER_ONE) ? LAYER_ONE_K : SPF_TAB[ver][lay][10:3];
      prod = k * NUM_TAB[ver][fri];
      return prod[SCALE_W-1:0];
   endfunction

endpackage

`default_nettype wire

@@ rtl/mafh_if.sv @@
// ---------------------------------------------------------------------------
// MPEG audio frame header evaluator - channel interfaces
// Valid/ready channels for header words in and evaluation words out.
// ---------------------------------------------------------------------------
`default_nettype none

interface mafh_req_if;
   logic       valid;
   logic       ready;
   logic       version_bit;
   logic [1:0] layer_code;
   logic [3:0] rate_index;
   logic [1:0] freq_index;
   logic       pad_flag;
   logic [1:0] chan_mode;

   modport source (output valid, version_bit, layer_code, rate_index, freq_index, pad_flag,
                   chan_mode, input ready);
   modport sink (input valid, version_bit, layer_code, rate_index, freq_index, pad_flag,
                 chan_mode, output ready);
endinterface

interface mafh_rsp_if;
   logic        valid;
   logic        ready;
   logic [8:0]  bitrate_kbps;
   logic [15:0] sample_rate_hz;
   logic [1:0]  channel_total;
   logic [10:0] samples_in_frame;
   logic [10:0] frame_bytes;
   logic [2:0]  status;

   modport source (output valid, bitrate_kbps, sample_rate_hz, channel_total,
                   samples_in_frame, frame_bytes, status, input ready);
   modport sink (input valid, bitrate_kbps, sample_rate_hz, channel_total, samples_in_frame,
                 frame_bytes, status, output ready);
endinterface

`default_nettype wire

@@ rtl/mpeg_audio_frame_header_eval_top.sv @@
// ---------------------------------------------------------------------------
// MPEG audio frame header evaluator - top level
// Five-stage pipeline: lookup, scale, reciprocal multiply, back-multiply, correct and pad.
// An accepted word is registered in s1, then moves through s2, s3, s4 and s5 in order.
// Throughput: one word per cycle unless the output stalls; then only blocked stages freeze.
// Reset clears the stage valid bits; payload registers are not reset.
// ---------------------------------------------------------------------------
`default_nettype none

`include "mpeg_audio_frame_header_eval_top_defines.svh"

module mpeg_audio_frame_header_eval_top (
   input  wire         clock,
   input  wire         reset,
   mafh_req_if.sink    req_chan,
   mafh_rsp_if.source  rsp_chan
);
   import mafh_pkg::*;

   logic [PIPE_DEPTH-1:0] vld_ff;
   logic [PIPE_DEPTH-1:0] vld_in;
   logic [PIPE_DEPTH-1:0] adv;

   hdr_info_type          s1_info_ff, s1_info_in;
   logic [SCALE_W-1:0]    s1_scale_ff, s1_scale_in;
   logic [DEN_W-1:0]      s1_den_ff, s1_den_in;
   logic [RECIP_W-1:0]    s1_recip_ff, s1_recip_in;

   hdr_info_type          s2_info_ff;
   logic [X_W-1:0]        s2_x_ff, s2_x_in;
   logic [DEN_W-1:0]      s2_den_ff;
   logic [RECIP_W-1:0]    s2_recip_ff;
   logic [20:0]           s2_prod;

   hdr_info_type          s3_info_ff;
   logic [X_W-1:0]        s3_x_ff;
   logic [DEN_W-1:0]      s3_den_ff;
   logic [Q_W-1:0]        s3_qe_ff, s3_qe_in;
   logic [X_W+RECIP_W-1:0] s3_prod;

   hdr_info_type          s4_info_ff;
   logic [X_W-1:0]        s4_x_ff;
   logic [DEN_W-1:0]      s4_den_ff;
   logic [Q_W-1:0]        s4_qe_ff;
   logic [X_W-1:0]        s4_qd_ff, s4_qd_in;

   hdr_info_type          s5_info_ff;
   logic [10:0]           s5_bytes_ff, s5_bytes_in;
   logic [X_W-1:0]        s5_rem;
   logic [Q_W-1:0]        s5_q;
   logic [10:0]           s5_base;

   logic                  est_in_range;
   logic                  rsp_err;
   logic                  rsp_good;
   logic                  len_zero;
   logic                  pipe_stuck;
   logic                  req_take;

   // stall chain
   always_comb begin
      adv[PIPE_DEPTH-1] = !vld_ff[PIPE_DEPTH-1] || rsp_chan.ready;
      for (int i = PIPE_DEPTH - 2; i >= 0; i--) begin
         adv[i] = !vld_ff[i] || adv[i+1];
      end
      vld_in[0] = adv[0] ? req_chan.valid : vld_ff[0];
      for (int i = 1; i < PIPE_DEPTH; i++) begin
         vld_in[i] = adv[i] ? vld_ff[i-1] : vld_ff[i];
      end
   end

   assign req_chan.ready = adv[0];

   // stage 1: table lookup
   always_comb begin
      s1_info_in.kbps      = KBPS_TAB[req_chan.version_bit][req_chan.layer_code]
                                     [req_chan.rate_index];
      s1_info_in.hz        = HZ_TAB[req_chan.version_bit][req_chan.freq_index];
      s1_info_in.chans     = CHAN_TAB[req_chan.chan_mode];
      s1_info_in.spf       = SPF_TAB[req_chan.version_bit][req_chan.layer_code];
      s1_info_in.status    = status_eval(req_chan.layer_code, req_chan.freq_index,
                                         req_chan.rate_index);
      s1_info_in.slot      = req_chan.pad_flag ? SLOT_TAB[req_chan.layer_code] : 3'd0;
      s1_info_in.layer_one = (req_chan.layer_code == LAYER_ONE);
      s1_scale_in          = scale_eval(req_chan.version_bit, req_chan.layer_code,
                                        req_chan.freq_index);
      s1_den_in            = DEN_TAB[req_chan.version_bit][req_chan.freq_index];
      s1_recip_in          = RECIP_TAB[req_chan.version_bit][req_chan.freq_index];
   end

   // stage 2: numerator, always below 2^20 for every table entry
   assign s2_prod = s1_info_ff.kbps * s1_scale_ff;
   assign s2_x_in = s2_prod[X_W-1:0];

   // stage 3: quotient estimate, low by at most one
   assign s3_prod  = s2_x_ff * s2_recip_ff;
   assign s3_qe_in = s3_prod[RECIP_SHIFT+Q_W-1:RECIP_SHIFT];

   // stage 4: back-multiply
   assign s4_qd_in = s3_qe_ff * s3_den_ff;

   // stage 5: correct, scale, pad, mask
   always_comb begin
      s5_rem  = s4_x_ff - s4_qd_ff;
      s5_q    = s4_qe_ff + ((s5_rem >= {{(X_W-DEN_W){1'b0}}, s4_den_ff}) ? 11'd1 : 11'd0);
      s5_base = s4_info_ff.layer_one ? {s5_q[8:0], 2'b00} : s5_q;
      if (s4_info_ff.status == STAT_OK) begin
         s5_bytes_in = s5_base + {8'd0, s4_info_ff.slot};
      end else begin
         s5_bytes_in = 11'd0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else begin
         vld_ff <= vld_in;
      end
   end

   always_ff @(posedge clock) begin
      if (adv[0]) begin
         s1_info_ff  <= s1_info_in;
         s1_scale_ff <= s1_scale_in;
         s1_den_ff   <= s1_den_in;
         s1_recip_ff <= s1_recip_in;
      end
      if (adv[1]) begin
         s2_info_ff  <= s1_info_ff;
         s2_x_ff     <= s2_x_in;
         s2_den_ff   <= s1_den_ff;
         s2_recip_ff <= s1_recip_ff;
      end
      if (adv[2]) begin
         s3_info_ff <= s2_info_ff;
         s3_x_ff    <= s2_x_ff;
         s3_den_ff  <= s2_den_ff;
         s3_qe_ff   <= s3_qe_in;
      end
      if (adv[3]) begin
         s4_info_ff <= s3_info_ff;
         s4_x_ff    <= s3_x_ff;
         s4_den_ff  <= s3_den_ff;
         s4_qe_ff   <= s3_qe_ff;
         s4_qd_ff   <= s4_qd_in;
      end
      if (adv[4]) begin
         s5_info_ff  <= s4_info_ff;
         s5_bytes_ff <= s5_bytes_in;
      end
   end

   assign rsp_chan.valid            = vld_ff[PIPE_DEPTH-1];
   assign rsp_chan.bitrate_kbps     = s5_info_ff.kbps;
   assign rsp_chan.sample_rate_hz   = s5_info_ff.hz;
   assign rsp_chan.channel_total    = s5_info_ff.chans;
   assign rsp_chan.samples_in_frame = s5_info_ff.spf;
   assign rsp_chan.frame_bytes      = s5_bytes_ff;
   assign rsp_chan.status           = s5_info_ff.status;

   assign est_in_range = (s4_x_ff >= s4_qd_ff) &&
                         ((s4_x_ff - s4_qd_ff) < {{(X_W-DEN_W-1){1'b0}}, s4_den_ff, 1'b0});
   assign rsp_err      = rsp_chan.valid && (rsp_chan.status != STAT_OK);
   assign rsp_good     = rsp_chan.valid && (rsp_chan.status == STAT_OK);
   assign len_zero     = (rsp_chan.frame_bytes == 11'd0);
   assign pipe_stuck   = (&vld_ff) && !rsp_chan.ready;
   assign req_take     = req_chan.valid && req_chan.ready;

   `MAFH_ASSERT_IMP(a_est_within_one, clock, reset, vld_ff[3], est_in_range, "bad estimate")
   `MAFH_ASSERT_IMP(a_err_no_length, clock, reset, rsp_err, len_zero, "length on error")
   `MAFH_ASSERT_IMP(a_ok_has_length, clock, reset, rsp_good, !len_zero, "zero length")
   `MAFH_ASSERT_IMP(a_full_blocks_in, clock, reset, pipe_stuck, !req_chan.ready, "full but ready")
   `MAFH_ASSERT_NXT(a_accept_enters, clock, reset, req_take, vld_ff[0], "accepted word lost")

endmodule

`default_nettype wire
